>>> src/rmst_pkg.sv
// ============================================================================
// Range minimum segment tree: shared types and constants
// Request and result words, the classified command word passed from the
// front end to the tree walker, and the walker state encoding.
// ============================================================================
package rmst_pkg;

    // Request type codes.
    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Leaf count register width and its value after reset.
    localparam int          LEAVES_W     = 11;
    localparam logic [10:0] LEAVES_RESET = 11'd1024;

    // One request word.
    typedef struct packed {
        logic               req_type;
        logic [9:0]         position;
        logic signed [31:0] leaf_value;
        logic [10:0]        range_low;
        logic [10:0]        range_high;
    } req_t;

    // One result word.
    typedef struct packed {
        logic signed [31:0] min_value;
        logic               was_query;
        logic               bad_request;
    } res_t;

    // Classification made by the front end.
    typedef enum logic [2:0] {
        CMD_SET,
        CMD_QUERY,
        CMD_EMPTY_QUERY,
        CMD_BAD_SET,
        CMD_BAD_QUERY
    } cmd_kind_t;

    // Command word held in the queue between front end and walker.
    typedef struct packed {
        cmd_kind_t kind;
        req_t      req;
    } cmd_t;

    // Tree walker states.
    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SET_LEAF,
        BK_SET_CLIMB,
        BK_QRY_LEFT,
        BK_QRY_RIGHT,
        BK_QRY_FINISH,
        BK_DONE
    } bk_state_t;

endpackage

>>> src/rmst_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/rmst_front.sv
// ============================================================================
// Range minimum segment tree: request front end
// Accepts request words, checks them against the leaf count and classifies
// them into commands, holding one command until the queue takes it.
// ============================================================================
module rmst_front #(
    parameter int MAX_LEAVES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(MAX_LEAVES+1)-1:0] n,
    input  logic                          clearing,
    input  logic                          push,
    input  rmst_pkg::req_t                req,
    output logic                          full,
    output logic                          q_push,
    output rmst_pkg::cmd_t                q_cmd,
    input  logic                          q_full
);
    import rmst_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_t      cmd_reg;
    cmd_kind_t kind;
    logic      accept;

    // Classify the incoming request against the leaf count.
    always_comb
    begin
        priority if (req.req_type == REQ_SET)
        begin
            kind = (32'(req.position) >= 32'(n)) ? CMD_BAD_SET : CMD_SET;
        end
        else if ((32'(req.range_low) > 32'(n)) || (32'(req.range_high) > 32'(n)))
        begin
            kind = CMD_BAD_QUERY;
        end
        else if (req.range_low >= req.range_high)
        begin
            kind = CMD_EMPTY_QUERY;
        end
        else
        begin
            kind = CMD_QUERY;
        end
    end

    // Handshake: hold the command until the queue has room.
    assign full       = clearing || (valid_reg && q_full);
    assign accept     = push && !full;
    assign q_push     = valid_reg && !q_full;
    assign q_cmd      = cmd_reg;
    assign valid_next = accept ? 1'b1 : (q_push ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Command word register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= '{kind: kind, req: req};
        end
    end

endmodule

>>> src/rmst_cmd_queue.sv
// ============================================================================
// Range minimum segment tree: command queue
// Two-entry queue that decouples the front end from the tree walker.
// ============================================================================
module rmst_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rmst_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output rmst_pkg::cmd_t dout,
    output logic           empty
);
    import rmst_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> src/rmst_back.sv
// ============================================================================
// Range minimum segment tree: tree walker
// Owns the node memory. Clears it after reset, then executes one command
// at a time: a set climbs from the leaf to the root, a query walks both
// range ends upward. Results wait in an output register.
// ============================================================================
module rmst_back #(
    parameter int MAX_LEAVES = 1024,
    parameter int VALUE_W    = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(MAX_LEAVES+1)-1:0] n,
    input  logic                            q_empty,
    input  rmst_pkg::cmd_t                  q_cmd,
    output logic                            q_pop,
    output logic                            clearing,
    input  logic                            pop,
    output logic                            empty,
    output rmst_pkg::res_t                  res
);
    import rmst_pkg::*;

    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = AW + 1;
    localparam int LIN_W = (VALUE_W < 32) ? VALUE_W : 32;
    localparam int OW    = (VALUE_W > 32) ? VALUE_W : 32;
    localparam logic signed [VALUE_W-1:0] NEUTRAL = {1'b0, {(VALUE_W-1){1'b1}}};

    function automatic logic signed [VALUE_W-1:0] min2(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    bk_state_t                  state_reg, state_next;
    logic [AW-1:0]              clr_idx_reg, clr_idx_next;
    logic [IW-1:0]              node_reg, node_next;
    logic [IW-1:0]              r_reg, r_next;
    logic signed [VALUE_W-1:0]  cur_reg, cur_next;
    logic signed [VALUE_W-1:0]  acc_r_reg, acc_r_next;
    logic                       pend_l_reg, pend_l_next;
    logic                       pend_r_reg, pend_r_next;
    logic signed [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                       res_query_reg, res_query_next;
    logic                       res_bad_reg, res_bad_next;
    logic                       out_valid_reg, out_valid_next;
    res_t                       out_reg, out_next;
    logic                       out_load;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;

    logic signed [VALUE_W-1:0]  rd_value;
    logic signed [VALUE_W-1:0]  leaf_ext;
    logic signed [VALUE_W-1:0]  climb_min;
    logic [IW-1:0]              parent;
    logic [IW-1:0]              r_dec;
    logic signed [OW-1:0]       res_wide;

    // Node memory.
    rmst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Helper values for the walk.
    assign rd_value  = $signed(ram_rdata);
    assign leaf_ext  = VALUE_W'($signed(q_cmd.req.leaf_value[LIN_W-1:0]));
    assign climb_min = min2(cur_reg, rd_value);
    assign parent    = node_reg >> 1;
    assign r_dec     = r_reg - IW'(1);
    assign res_wide  = OW'(res_value_reg);

    assign clearing = (state_reg == BK_CLEAR);
    assign empty    = !out_valid_reg;
    assign res      = out_reg;

    // Walker sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        node_next      = node_reg;
        r_next         = r_reg;
        cur_next       = cur_reg;
        acc_r_next     = acc_r_reg;
        pend_l_next    = pend_l_reg;
        pend_r_next    = pend_r_reg;
        res_value_next = res_value_reg;
        res_query_next = res_query_reg;
        res_bad_next   = res_bad_reg;
        out_load       = 1'b0;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = node_reg[AW-1:0];
        ram_wdata      = cur_reg;
        ram_re         = 1'b0;
        ram_raddr      = node_reg[AW-1:0];

        unique case (state_reg)
            BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = NEUTRAL;
                if (clr_idx_reg == AW'(DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end

            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop          = 1'b1;
                    res_value_next = NEUTRAL;
                    res_query_next = 1'b0;
                    res_bad_next   = 1'b0;
                    unique case (q_cmd.kind)
                        CMD_SET:
                        begin
                            node_next  = IW'(q_cmd.req.position) + IW'(n);
                            cur_next   = leaf_ext;
                            state_next = BK_SET_LEAF;
                        end
                        CMD_QUERY:
                        begin
                            node_next      = IW'(q_cmd.req.range_low) + IW'(n);
                            r_next         = IW'(q_cmd.req.range_high) + IW'(n);
                            cur_next       = NEUTRAL;
                            acc_r_next     = NEUTRAL;
                            pend_l_next    = 1'b0;
                            pend_r_next    = 1'b0;
                            res_query_next = 1'b1;
                            state_next     = BK_QRY_LEFT;
                        end
                        CMD_EMPTY_QUERY:
                        begin
                            res_query_next = 1'b1;
                            state_next     = BK_DONE;
                        end
                        CMD_BAD_SET:
                        begin
                            res_bad_next = 1'b1;
                            state_next   = BK_DONE;
                        end
                        CMD_BAD_QUERY:
                        begin
                            res_query_next = 1'b1;
                            res_bad_next   = 1'b1;
                            state_next     = BK_DONE;
                        end
                        default:
                        begin
                            state_next = BK_DONE;
                        end
                    endcase
                end
            end

            // Write the leaf and fetch its sibling.
            BK_SET_LEAF:
            begin
                ram_we    = 1'b1;
                ram_waddr = node_reg[AW-1:0];
                ram_wdata = cur_reg;
                if (node_reg > IW'(1))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(node_reg ^ IW'(1));
                    state_next = BK_SET_CLIMB;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end

            // One level per cycle: write the parent, fetch the parent's sibling.
            BK_SET_CLIMB:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent[AW-1:0];
                ram_wdata = climb_min;
                cur_next  = climb_min;
                node_next = parent;
                if (parent > IW'(1))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(parent ^ IW'(1));
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end

            // Fold in the right-end node, then test and fetch the left end.
            BK_QRY_LEFT:
            begin
                if (pend_r_reg)
                begin
                    acc_r_next = min2(rd_value, acc_r_reg);
                end
                pend_r_next = 1'b0;
                if (node_reg >= r_reg)
                begin
                    state_next = BK_QRY_FINISH;
                end
                else
                begin
                    if (node_reg[0])
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = node_reg[AW-1:0];
                        node_next   = node_reg + IW'(1);
                        pend_l_next = 1'b1;
                    end
                    state_next = BK_QRY_RIGHT;
                end
            end

            // Fold in the left-end node, fetch the right end, move up a level.
            BK_QRY_RIGHT:
            begin
                if (pend_l_reg)
                begin
                    cur_next = climb_min;
                end
                pend_l_next = 1'b0;
                if (r_reg[0])
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_dec[AW-1:0];
                    pend_r_next = 1'b1;
                end
                node_next  = node_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = BK_QRY_LEFT;
            end

            BK_QRY_FINISH:
            begin
                res_value_next = min2(cur_reg, acc_r_reg);
                state_next     = BK_DONE;
            end

            BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_next = '{min_value:   $signed(res_wide[31:0]),
                     was_query:   res_query_reg,
                     bad_request: res_bad_reg};
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            pend_l_reg    <= 1'b0;
            pend_r_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            pend_l_reg    <= pend_l_next;
            pend_r_reg    <= pend_r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        r_reg         <= r_next;
        cur_reg       <= cur_next;
        acc_r_reg     <= acc_r_next;
        res_value_reg <= res_value_next;
        res_query_reg <= res_query_next;
        res_bad_reg   <= res_bad_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> src/range_min_segment_tree_core.sv
// ============================================================================
// Range minimum segment tree core
// Bottom-up segment tree with set and range-minimum requests.
// ============================================================================
// After reset the core sweeps its node memory to the neutral value, one node
// per cycle, so it shows full until all 2*MAX_LEAVES nodes are cleared. Each
// request then holds the tree walker for a time set by the tree height,
// because every level needs a read from the single read port of the node
// memory. A set request writes the leaf, then climbs one level at a time,
// since each level's sibling read feeds the parent write. A query walks two
// states per level to read up to two nodes. Rejected and empty requests skip
// the walk. Requests run one at a time; the front end and a two-entry queue
// keep taking words while the walker is busy, and a finished result waits in
// an output register. Change the leaf count only while the core is idle, and
// reload all leaves afterward.
module range_min_segment_tree_core #(
    parameter int MAX_LEAVES = 1024,
    parameter int VALUE_W    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  rmst_pkg::req_t                     req,
    output logic                               empty,
    input  logic                               pop,
    output rmst_pkg::res_t                     res,
    input  logic                               cfg_wr_en,
    input  logic [rmst_pkg::LEAVES_W-1:0]      cfg_wr_data
);
    import rmst_pkg::*;

    localparam int NW = $clog2(MAX_LEAVES + 1);

    logic [LEAVES_W-1:0] leaves_reg;
    logic [31:0]         n_wide;
    logic [NW-1:0]       n;
    logic                clearing;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    cmd_t                front_cmd;
    cmd_t                q_cmd;

    // Leaf count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaves_reg <= LEAVES_RESET;
        end
        else if (cfg_wr_en)
        begin
            leaves_reg <= cfg_wr_data;
        end
    end

    // Clamp the leaf count to 1..MAX_LEAVES.
    always_comb
    begin
        priority if (leaves_reg == '0)
        begin
            n_wide = 32'd1;
        end
        else if (32'(leaves_reg) > 32'(MAX_LEAVES))
        begin
            n_wide = 32'(MAX_LEAVES);
        end
        else
        begin
            n_wide = 32'(leaves_reg);
        end
    end

    assign n = n_wide[NW-1:0];

    rmst_front #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .n        (n),
        .clearing (clearing),
        .push     (push),
        .req      (req),
        .full     (full),
        .q_push   (q_push),
        .q_cmd    (front_cmd),
        .q_full   (q_full)
    );

    rmst_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_cmd),
        .empty (q_empty)
    );

    rmst_back #(
        .MAX_LEAVES (MAX_LEAVES),
        .VALUE_W    (VALUE_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .n        (n),
        .q_empty  (q_empty),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

endmodule

>>> src/rmst_checker.sv
// ============================================================================
// Range minimum segment tree: port checker
// Watches the core's ports for result ordering, stall behavior and the
// neutral value on acknowledgements and rejected requests.
// ============================================================================
module rmst_checker #(
    parameter int VALUE_W = 32
) (
    input logic           clk,
    input logic           rst_n,
    input logic           push,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input rmst_pkg::res_t res
);
    import rmst_pkg::*;

    localparam logic [31:0] NEUTRAL_OUT = (VALUE_W > 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << (VALUE_W - 1)) - 64'd1);

    logic [3:0] outstanding_reg;
    logic [3:0] outstanding_next;

    // Count words accepted but not yet delivered.
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if ((push && !full) && !(pop && !empty))
        begin
            outstanding_next = outstanding_reg + 4'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            outstanding_next = outstanding_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 4'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A result only appears for a word that was accepted.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outstanding_reg != 4'd0))
        else $error("result shown with no request outstanding");

    // A waiting result holds until taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res)))
        else $error("result changed or vanished while stalled");

    // Set acknowledgements and rejected requests carry the neutral value.
    a_neutral_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (!res.was_query || res.bad_request)) |->
        (res.min_value == NEUTRAL_OUT))
        else $error("acknowledge or rejected request without neutral value");

    // The memory clear keeps the core closed and empty as reset ends.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (full && empty))
        else $error("core open right after reset");

endmodule

bind range_min_segment_tree_core rmst_checker #(
    .VALUE_W (VALUE_W)
) u_rmst_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .res   (res)
);

>>> tb/sv/tb_range_min_segment_tree_core.sv
`timescale 1ns / 100ps
// ============================================================================
// Range minimum segment tree core testbench
// Drives set and range-minimum request words through the input queue and
// checks every result word against a bit-exact mirror of the node memory.
// Covers the empty tree, the leaf-count limits, bad requests and long random
// traffic over several leaf counts, gaps on both sides save at 1024 leaves.
// ============================================================================
module tb_range_min_segment_tree_core;
    import rmst_pkg::*;

    localparam logic signed [31:0] NEUTRAL       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam int                 TREE_NODES    = 2048;
    localparam int                 MAX_LEAVES    = 1024;
    localparam int                 SETTLE_CYCLES = 40;
    localparam int                 STALL_LIMIT   = 20000;
    localparam int                 PHASE_WORDS   = 175;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                push        = 1'b0;
    logic                full;
    req_t                req_word    = '0;
    logic                empty;
    logic                pop         = 1'b0;
    res_t                res_word;
    logic                cfg_wr_en   = 1'b0;
    logic [LEAVES_W-1:0] cfg_wr_data = '0;

    // Mirror of the node memory and of the leaf-count register.
    logic signed [31:0]  tree_mirror [0:TREE_NODES-1];
    logic [LEAVES_W-1:0] leaf_count = LEAVES_RESET;

    res_t awaited_results [$];
    bit   gaps_on         = 1'b1;
    int   mismatches      = 0;
    int   results_seen    = 0;
    int   idle_cycles     = 0;
    int   set_words       = 0;
    int   query_words     = 0;
    int   rejected_words  = 0;
    int   settings_used   = 0;

    range_min_segment_tree_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req         (req_word),
        .empty       (empty),
        .pop         (pop),
        .res         (res_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The leaf count the core acts on: zero acts as one, anything above the
    // maximum acts as the maximum.
    function automatic int unsigned effective_leaves();
        int unsigned n;
        n = leaf_count;
        if (n < 1)
            n = 1;
        if (n > MAX_LEAVES)
            n = MAX_LEAVES;
        return n;
    endfunction

    function automatic logic signed [31:0] smaller(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    // Apply one request word to the mirror and return the result word it
    // should produce.
    function automatic res_t tree_result(req_t w);
        res_t               want;
        int unsigned        n;
        int unsigned        p;
        int unsigned        l;
        int unsigned        r;
        logic signed [31:0] acc_l;
        logic signed [31:0] acc_r;
        n                = effective_leaves();
        want.min_value   = NEUTRAL;
        want.was_query   = w.req_type;
        want.bad_request = 1'b0;
        if (w.req_type == REQ_SET)
        begin
            set_words++;
            if (w.position >= n)
                want.bad_request = 1'b1;
            else
            begin
                p = w.position + n;
                tree_mirror[p] = w.leaf_value;
                while (p > 1)
                begin
                    tree_mirror[p >> 1] = smaller(tree_mirror[p], tree_mirror[p ^ 1]);
                    p = p >> 1;
                end
            end
        end
        else
        begin
            query_words++;
            if (w.range_low > n || w.range_high > n)
                want.bad_request = 1'b1;
            else
            begin
                // Walk both ends of the half-open range upward.
                acc_l = NEUTRAL;
                acc_r = NEUTRAL;
                l = w.range_low + n;
                r = w.range_high + n;
                while (l < r)
                begin
                    if (l[0])
                    begin
                        acc_l = smaller(acc_l, tree_mirror[l]);
                        l++;
                    end
                    if (r[0])
                    begin
                        r--;
                        acc_r = smaller(tree_mirror[r], acc_r);
                    end
                    l = l >> 1;
                    r = r >> 1;
                end
                want.min_value = smaller(acc_l, acc_r);
            end
        end
        if (want.bad_request)
            rejected_words++;
        return want;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("[%0t] MISMATCH word %0d %s: expected %0d, got %0d",
                 $time, results_seen, what, want, got);
    endtask

    // Random word; the caller overrides the fields that matter.
    function automatic req_t random_word();
        req_t w;
        w.req_type   = logic'($urandom_range(1));
        w.position   = 10'($urandom_range(1023));
        w.leaf_value = $urandom;
        w.range_low  = 11'($urandom_range(2047));
        w.range_high = 11'($urandom_range(2047));
        return w;
    endfunction

    // Leaf values: extremes, a narrow band with many ties, or anything.
    function automatic logic signed [31:0] random_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0: return MOST_NEGATIVE;
                1: return NEUTRAL;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        if (pick < 40)
            return $signed(32'($urandom_range(40))) - 32'sd20;
        return $urandom;
    endfunction

    // Present one word, with random gaps, until the core takes it. Entered
    // and left at a falling edge.
    task automatic send_request(input req_t w);
        while (gaps_on && $urandom_range(99) < 30)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        req_word <= w;
        do
            @(posedge clk);
        while (full !== 1'b0);
        awaited_results.push_back(tree_result(w));
        @(negedge clk);
    endtask

    task automatic send_set(input int unsigned pos, input logic signed [31:0] value);
        req_t w;
        w            = random_word();
        w.req_type   = REQ_SET;
        w.position   = 10'(pos);
        w.leaf_value = value;
        send_request(w);
    endtask

    task automatic send_query(input int unsigned lo, input int unsigned hi);
        req_t w;
        w            = random_word();
        w.req_type   = REQ_QUERY;
        w.range_low  = 11'(lo);
        w.range_high = 11'(hi);
        send_request(w);
    endtask

    // Let every awaited word come back, then give the walker time to settle.
    task automatic wait_idle();
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_leaf_count(input logic [LEAVES_W-1:0] count);
        wait_idle();
        cfg_wr_data <= count;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        leaf_count  = count;
        settings_used++;
    endtask

    // Empty tree after reset, extreme values at both ends, empty and
    // reversed ranges, and bounds past the last leaf.
    task automatic test_empty_tree();
        send_query(0, 1024);
        send_set(0, MOST_NEGATIVE);
        send_set(1023, NEUTRAL);
        send_set(512, 32'sd0);
        send_set(1, -32'sd1);
        send_query(0, 1024);
        send_query(1, 1024);
        send_query(1023, 1024);
        send_query(2, 1023);
        send_query(7, 7);
        send_query(9, 3);
        send_query(0, 1025);
        send_query(2047, 0);
    endtask

    // Leaf counts of zero and of the all-ones value, and a two-leaf tree.
    // The node memory is not cleared between them.
    task automatic test_leaf_count_limits();
        write_leaf_count(11'd0);
        send_set(0, 32'sd42);
        send_set(1, 32'sd3);
        send_query(0, 1);
        send_query(0, 2);
        write_leaf_count(11'd2047);
        send_set(1023, -32'sd5);
        send_query(0, 1024);
        send_query(1024, 1024);
        send_query(1024, 1025);
        write_leaf_count(11'd2);
        send_set(1, 32'sd7);
        send_query(0, 2);
        send_set(2, 32'sd9);
    endtask

    // Random traffic over several leaf counts. Small trees are loaded in
    // full first; then mostly valid sets and queries, some bad words.
    task automatic test_random_traffic();
        int unsigned        counts [10] = '{5, 2, 33, 1024, 17, 1, 300, 64, 8, 1000};
        int unsigned        n;
        int unsigned        lo;
        int unsigned        pick;
        int unsigned        swap_at;
        int unsigned        held;
        int unsigned        load_order [$];
        int                 sent;
        req_t               w;
        for (int ph = 0; ph < 10; ph++)
        begin
            write_leaf_count(11'(counts[ph]));
            n       = effective_leaves();
            gaps_on = (counts[ph] != 1024);
            sent    = 0;
            if (n <= 64)
            begin
                load_order.delete();
                for (int unsigned i = 0; i < n; i++)
                    load_order.push_back(i);
                for (int unsigned i = n - 1; i > 0; i--)
                begin
                    swap_at             = $urandom_range(i);
                    held                = load_order[i];
                    load_order[i]       = load_order[swap_at];
                    load_order[swap_at] = held;
                end
                foreach (load_order[i])
                begin
                    send_set(load_order[i], random_value());
                    sent++;
                end
            end
            while (sent < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    send_set($urandom_range(n - 1), random_value());
                else if (pick < 85)
                begin
                    if ($urandom_range(19) == 0)
                        send_query(0, n);
                    else
                    begin
                        lo = $urandom_range(n - 1);
                        send_query(lo, $urandom_range(n, lo + 1));
                    end
                end
                else if (pick < 93)
                begin
                    // Fully random word, often out of bounds.
                    w = random_word();
                    send_request(w);
                end
                else
                begin
                    lo = $urandom_range(n);
                    send_query(lo, $urandom_range(lo));
                end
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    // Result side: random stalls on pop.
    always @(negedge clk)
        pop <= !(gaps_on && $urandom_range(99) < 30);

    // Compare each popped result word with the oldest awaited one.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
                report_mismatch("arrived with nothing awaited", 0, res_word.min_value);
            else
            begin
                want = awaited_results.pop_front();
                if (res_word.min_value !== want.min_value)
                    report_mismatch("min_value", want.min_value, res_word.min_value);
                if (res_word.was_query !== want.was_query)
                    report_mismatch("was_query", want.was_query, res_word.was_query);
                if (res_word.bad_request !== want.bad_request)
                    report_mismatch("bad_request", want.bad_request, res_word.bad_request);
            end
        end
    end

    // Count cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((push && full === 1'b0) || (pop && empty === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < TREE_NODES; i++)
            tree_mirror[i] = NEUTRAL;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_empty_tree();
        test_leaf_count_limits();
        test_random_traffic();

        wait_idle();
        $display("Checked %0d result words: %0d sets and %0d queries, %0d of them rejected,",
                 results_seen, set_words, query_words, rejected_words);
        $display("over %0d leaf-count writes including zero, one and the all-ones value.",
                 settings_used);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
src/rmst_pkg.sv
src/rmst_ram.sv
src/rmst_front.sv
src/rmst_cmd_queue.sv
src/rmst_back.sv
src/range_min_segment_tree_core.sv
src/rmst_checker.sv
tb/sv/tb_range_min_segment_tree_core.sv
